@@ src/bjac_pkg.sv @@
// Shared types and constants for the bitset comparison and overlap ratio block.
package bjac_pkg;

    localparam int MAX_ITEMS = 64;
    localparam int SET_W     = 64;
    localparam int CNT_W     = 7;
    localparam int RATIO_W   = 17;
    localparam int BYTES     = SET_W / 8;

    localparam logic [CNT_W-1:0] SET_SIZE_RESET = 7'd64;
    localparam logic [CNT_W-1:0] SET_SIZE_MAX   = CNT_W'(MAX_ITEMS);

    typedef logic [BYTES-1:0][3:0] byte_cnt_t;

    typedef struct packed {
        logic [SET_W-1:0] union_bits;
        logic [SET_W-1:0] common_bits;
        byte_cnt_t        union_bytes;
        byte_cnt_t        common_bytes;
        logic             same_sets;
        logic             a_within_b;
        logic             a_covers_b;
        logic             a_empty;
    } mask_stage_t;

    typedef struct packed {
        logic [SET_W-1:0]   union_bits;
        logic [SET_W-1:0]   common_bits;
        logic [CNT_W-1:0]   union_count;
        logic [CNT_W-1:0]   common_count;
        logic               same_sets;
        logic               a_within_b;
        logic               a_covers_b;
        logic               a_empty;
        logic [CNT_W-1:0]   rem;
        logic [RATIO_W-1:0] quot;
    } item_stage_t;

endpackage

@@ src/bjac_div_step.sv @@
// A group of restoring division steps that shift in zero numerator bits.
module bjac_div_step
    import bjac_pkg::*;
#(
    parameter int STEPS = 6
)
(
    input  logic [CNT_W-1:0] rem_in,
    input  logic [CNT_W-1:0] divisor,
    output logic [CNT_W-1:0] rem_out,
    output logic [STEPS-1:0] quot_bits
);

    always_comb
    begin
        logic [CNT_W:0] r;
        r = {1'b0, rem_in};
        quot_bits = '0;
        for (int i = 0; i < STEPS; i++)
        begin
            r = {r[CNT_W-1:0], 1'b0};
            if (r >= {1'b0, divisor})
            begin
                r = r - {1'b0, divisor};
                quot_bits[STEPS-1-i] = 1'b1;
            end
        end
        rem_out = r[CNT_W-1:0];
    end

endmodule

@@ src/bitset_compare_jaccard_top.sv @@
// Top level of the bitset comparison block with union, intersection and overlap ratio.
// Each accepted transaction is registered in every stage in turn before it reaches output valid.
// Throughput is one transaction per cycle; each stage holds its item until the next one frees.
// The stages are masking, population count, and three groups of division steps for the ratio.
// Reset clears all stage valid bits and sets set_size to 64.
module bitset_compare_jaccard_top
    import bjac_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [CNT_W-1:0]   cfg_wdata,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [SET_W-1:0]   set_a,
    input  logic [SET_W-1:0]   set_b,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [SET_W-1:0]   union_bits,
    output logic [SET_W-1:0]   common_bits,
    output logic [CNT_W-1:0]   union_count,
    output logic [CNT_W-1:0]   common_count,
    output logic               same_sets,
    output logic               a_within_b,
    output logic               a_covers_b,
    output logic               a_empty,
    output logic [RATIO_W-1:0] overlap_ratio
);

    localparam int D1_STEPS = 5;
    localparam int D2_STEPS = 6;
    localparam int D3_STEPS = 5;

    function automatic logic [3:0] popcnt8(input logic [7:0] v);
        logic [3:0] n;
        n = '0;
        for (int i = 0; i < 8; i++)
        begin
            n = n + 4'(v[i]);
        end
        return n;
    endfunction

    function automatic logic [CNT_W-1:0] sum_bytes(input byte_cnt_t bc);
        logic [CNT_W-1:0] n;
        n = '0;
        for (int i = 0; i < BYTES; i++)
        begin
            n = n + CNT_W'(bc[i]);
        end
        return n;
    endfunction

    logic [CNT_W-1:0] set_size_reg;

    logic        s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg;
    logic        s1_load, s2_load, s3_load, s4_load, s5_load;
    mask_stage_t s1_reg, s1_next;
    item_stage_t s2_reg, s2_next;
    item_stage_t s3_reg, s3_next;
    item_stage_t s4_reg, s4_next;
    item_stage_t s5_reg, s5_next;

    logic [CNT_W-1:0]    d1_rem, d2_rem, d3_rem;
    logic [D1_STEPS-1:0] d1_quot;
    logic [D2_STEPS-1:0] d2_quot;
    logic [D3_STEPS-1:0] d3_quot;
    logic                top_bit;
    logic [CNT_W-1:0]    top_rem;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_size_reg <= SET_SIZE_RESET;
        end
        else if (cfg_we)
        begin
            set_size_reg <= cfg_wdata;
        end
    end

    assign s5_load  = !s5_valid_reg || out_ready;
    assign s4_load  = !s4_valid_reg || s5_load;
    assign s3_load  = !s3_valid_reg || s4_load;
    assign s2_load  = !s2_valid_reg || s3_load;
    assign s1_load  = !s1_valid_reg || s2_load;
    assign in_ready = s1_load;

    always_comb
    begin
        logic [CNT_W-1:0] size_eff;
        logic [SET_W-1:0] mask;
        logic [SET_W-1:0] a;
        logic [SET_W-1:0] b;
        size_eff = (set_size_reg > SET_SIZE_MAX) ? SET_SIZE_MAX : set_size_reg;
        for (int i = 0; i < SET_W; i++)
        begin
            mask[i] = (CNT_W'(i) < size_eff);
        end
        a = set_a & mask;
        b = set_b & mask;
        s1_next.union_bits  = a | b;
        s1_next.common_bits = a & b;
        for (int i = 0; i < BYTES; i++)
        begin
            s1_next.union_bytes[i]  = popcnt8(s1_next.union_bits[8*i +: 8]);
            s1_next.common_bytes[i] = popcnt8(s1_next.common_bits[8*i +: 8]);
        end
        s1_next.same_sets  = (a == b);
        s1_next.a_within_b = ((a & ~b) == '0);
        s1_next.a_covers_b = ((b & ~a) == '0);
        s1_next.a_empty    = (a == '0);
    end

    always_comb
    begin
        s2_next.union_bits   = s1_reg.union_bits;
        s2_next.common_bits  = s1_reg.common_bits;
        s2_next.union_count  = sum_bytes(s1_reg.union_bytes);
        s2_next.common_count = sum_bytes(s1_reg.common_bytes);
        s2_next.same_sets    = s1_reg.same_sets;
        s2_next.a_within_b   = s1_reg.a_within_b;
        s2_next.a_covers_b   = s1_reg.a_covers_b;
        s2_next.a_empty      = s1_reg.a_empty;
        s2_next.rem          = '0;
        s2_next.quot         = '0;
    end

    // The intersection never exceeds the union, so the integer part of the
    // ratio is one bit and is settled by a single compare.
    assign top_bit = (s2_reg.union_count != '0) &&
                     (s2_reg.common_count == s2_reg.union_count);
    assign top_rem = top_bit ? '0 : s2_reg.common_count;

    bjac_div_step #(.STEPS(D1_STEPS)) u_div1
    (
        .rem_in    (top_rem),
        .divisor   (s2_reg.union_count),
        .rem_out   (d1_rem),
        .quot_bits (d1_quot)
    );

    always_comb
    begin
        s3_next      = s2_reg;
        s3_next.rem  = d1_rem;
        s3_next.quot = {top_bit, d1_quot, {(RATIO_W-1-D1_STEPS){1'b0}}};
    end

    bjac_div_step #(.STEPS(D2_STEPS)) u_div2
    (
        .rem_in    (s3_reg.rem),
        .divisor   (s3_reg.union_count),
        .rem_out   (d2_rem),
        .quot_bits (d2_quot)
    );

    always_comb
    begin
        s4_next      = s3_reg;
        s4_next.rem  = d2_rem;
        s4_next.quot = s3_reg.quot;
        s4_next.quot[D3_STEPS +: D2_STEPS] = d2_quot;
    end

    bjac_div_step #(.STEPS(D3_STEPS)) u_div3
    (
        .rem_in    (s4_reg.rem),
        .divisor   (s4_reg.union_count),
        .rem_out   (d3_rem),
        .quot_bits (d3_quot)
    );

    always_comb
    begin
        s5_next      = s4_reg;
        s5_next.rem  = d3_rem;
        s5_next.quot = s4_reg.quot;
        s5_next.quot[D3_STEPS-1:0] = d3_quot;
        if (s4_reg.union_count == '0)
        begin
            s5_next.quot = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_load)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_load)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_load)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (s4_load)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
            if (s5_load)
            begin
                s5_valid_reg <= s4_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load && in_valid)
        begin
            s1_reg <= s1_next;
        end
        if (s2_load && s1_valid_reg)
        begin
            s2_reg <= s2_next;
        end
        if (s3_load && s2_valid_reg)
        begin
            s3_reg <= s3_next;
        end
        if (s4_load && s3_valid_reg)
        begin
            s4_reg <= s4_next;
        end
        if (s5_load && s4_valid_reg)
        begin
            s5_reg <= s5_next;
        end
    end

    assign out_valid     = s5_valid_reg;
    assign union_bits    = s5_reg.union_bits;
    assign common_bits   = s5_reg.common_bits;
    assign union_count   = s5_reg.union_count;
    assign common_count  = s5_reg.common_count;
    assign same_sets     = s5_reg.same_sets;
    assign a_within_b    = s5_reg.a_within_b;
    assign a_covers_b    = s5_reg.a_covers_b;
    assign a_empty       = s5_reg.a_empty;
    assign overlap_ratio = s5_reg.quot;

    a_ratio_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> overlap_ratio <= 17'd65536)
        else $error("Overlap ratio exceeds one.");

    a_count_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> common_count <= union_count)
        else $error("Intersection count exceeds union count.");

    a_empty_union: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && union_count == '0 |-> overlap_ratio == '0 && same_sets)
        else $error("Empty union gives a nonzero ratio or unequal sets.");

    a_same_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && same_sets |-> a_within_b && a_covers_b)
        else $error("Equal sets not flagged as subset and superset.");

    a_full_ratio: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && union_count != '0 && common_count == union_count
            |-> overlap_ratio == 17'd65536)
        else $error("Identical nonempty sets do not give a ratio of one.");

endmodule

@@ verif/tb_bitset_compare_jaccard_top.sv @@
// Testbench for the bitset comparison block: directed and random set pairs checked against a predictor.
module tb_bitset_compare_jaccard_top;
    import bjac_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY     = 5;
    localparam int HOLD_CYCLES = 60;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_ITEMS = 65;

    typedef struct {
        logic [SET_W-1:0]   union_bits;
        logic [SET_W-1:0]   common_bits;
        logic [CNT_W-1:0]   union_count;
        logic [CNT_W-1:0]   common_count;
        logic               same_sets;
        logic               a_within_b;
        logic               a_covers_b;
        logic               a_empty;
        logic [RATIO_W-1:0] overlap_ratio;
    } cmp_result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [CNT_W-1:0]   cfg_wdata = '0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [SET_W-1:0]   set_a = '0;
    logic [SET_W-1:0]   set_b = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [SET_W-1:0]   union_bits;
    logic [SET_W-1:0]   common_bits;
    logic [CNT_W-1:0]   union_count;
    logic [CNT_W-1:0]   common_count;
    logic               same_sets;
    logic               a_within_b;
    logic               a_covers_b;
    logic               a_empty;
    logic [RATIO_W-1:0] overlap_ratio;

    cmp_result_t        pending_cmp[$];
    logic [CNT_W-1:0]   set_size_now = SET_SIZE_RESET;
    bit                 tx_gaps = 1'b0;
    bit                 rx_stalls = 1'b0;
    bit                 hold_req = 1'b0;
    int                 errors = 0;
    int                 pairs_sent = 0;
    int                 results_seen = 0;
    int                 sizes_used = 0;
    int unsigned        cycle_count = 0;

    bitset_compare_jaccard_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .set_a         (set_a),
        .set_b         (set_b),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .union_bits    (union_bits),
        .common_bits   (common_bits),
        .union_count   (union_count),
        .common_count  (common_count),
        .same_sets     (same_sets),
        .a_within_b    (a_within_b),
        .a_covers_b    (a_covers_b),
        .a_empty       (a_empty),
        .overlap_ratio (overlap_ratio)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycle_count, pending_cmp.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic cmp_result_t predict_compare(input logic [SET_W-1:0] a,
                                                    input logic [SET_W-1:0] b,
                                                    input logic [CNT_W-1:0] size);
        cmp_result_t      r;
        logic [SET_W-1:0] keep;
        logic [SET_W-1:0] ma;
        logic [SET_W-1:0] mb;
        int               n;
        int               uc;
        int               cc;
        n = (size > MAX_ITEMS) ? MAX_ITEMS : int'(size);
        keep = (n >= SET_W) ? '1 : ((64'd1 << n) - 64'd1);
        ma = a & keep;
        mb = b & keep;
        r.union_bits = ma | mb;
        r.common_bits = ma & mb;
        uc = $countones(r.union_bits);
        cc = $countones(r.common_bits);
        r.union_count = CNT_W'(uc);
        r.common_count = CNT_W'(cc);
        r.same_sets = (ma == mb);
        r.a_within_b = ((ma & ~mb) == '0);
        r.a_covers_b = ((mb & ~ma) == '0);
        r.a_empty = (ma == '0);
        r.overlap_ratio = (uc == 0) ? '0 : RATIO_W'((cc << 16) / uc);
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [SET_W-1:0] want,
                                        input logic [SET_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endfunction

    always @(posedge clk)
    begin
        cmp_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (pending_cmp.size() == 0)
            begin
                $display("%0t: unexpected transaction on output, union_bits %0h",
                         $time, union_bits);
                errors++;
            end
            else
            begin
                want = pending_cmp.pop_front();
                check_field("union_bits", want.union_bits, union_bits);
                check_field("common_bits", want.common_bits, common_bits);
                check_field("union_count", want.union_count, union_count);
                check_field("common_count", want.common_count, common_count);
                check_field("same_sets", want.same_sets, same_sets);
                check_field("a_within_b", want.a_within_b, a_within_b);
                check_field("a_covers_b", want.a_covers_b, a_covers_b);
                check_field("a_empty", want.a_empty, a_empty);
                check_field("overlap_ratio", want.overlap_ratio, overlap_ratio);
            end
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [SET_W-1:0] rand_word();
        return {$urandom(), $urandom()};
    endfunction

    // The output side stalls at random, and holds off for a long stretch on request.
    initial
    begin
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            if (stall_left > 0)
            begin
                out_ready = 1'b0;
                stall_left--;
            end
            else
            begin
                out_ready = 1'b1;
                if (rx_stalls && $urandom_range(0, 99) < 20)
                    stall_left = gap_len();
            end
        end
    end

    task automatic send_pair(input logic [SET_W-1:0] a, input logic [SET_W-1:0] b);
        if (tx_gaps && $urandom_range(0, 99) < 30)
        begin
            in_valid = 1'b0;
            repeat (gap_len()) @(negedge clk);
        end
        set_a = a;
        set_b = b;
        in_valid = 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_cmp.push_back(predict_compare(a, b, set_size_now));
        pairs_sent++;
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid = 1'b0;
        while (pending_cmp.size() != 0)
            @(negedge clk);
        repeat (LATENCY) @(negedge clk);
    endtask

    task automatic write_set_size(input logic [CNT_W-1:0] value);
        drain();
        cfg_we = 1'b1;
        cfg_wdata = value;
        @(negedge clk);
        cfg_we = 1'b0;
        set_size_now = value;
        sizes_used++;
    endtask

    task automatic random_pairs(input int count);
        logic [SET_W-1:0] a;
        logic [SET_W-1:0] b;
        int               kind;
        repeat (count)
        begin
            a = rand_word();
            b = rand_word();
            kind = $urandom_range(0, 9);
            case (kind)
                0: b = a;
                1: b = a | b;
                2: b = a & b;
                3: a = '0;
                4:
                begin
                    a = a & rand_word() & rand_word();
                    b = b & rand_word() & rand_word();
                end
                5: b = ~a;
                6:
                begin
                    a = a | rand_word() | rand_word();
                    b = a ^ (64'd1 << $urandom_range(0, SET_W - 1));
                end
                default: ;
            endcase
            send_pair(a, b);
        end
    endtask

    task automatic test_reset_size();
        tx_gaps = 1'b1;
        rx_stalls = 1'b1;
        send_pair('0, '0);
        send_pair('1, '1);
        send_pair('1, '0);
        send_pair('0, '1);
        send_pair(64'h0000_0000_0000_00F0, 64'h0000_0000_0000_FFF0);
        send_pair(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
        send_pair(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0001);
        send_pair(64'h0000_0000_0000_0001, 64'h0000_0000_0000_0000);
        send_pair(64'hFFFF_FFFF_0000_0000, 64'hFFFF_0000_FFFF_0000);
        send_pair(64'h0123_4567_89AB_CDEF, 64'h0123_4567_89AB_CDEF);
    endtask

    task automatic test_size_extremes();
        write_set_size(7'd0);
        send_pair('1, '1);
        send_pair('1, 64'h1);
        write_set_size(7'd1);
        send_pair('1, '1);
        send_pair(64'hFFFF_FFFF_FFFF_FFFE, '1);
        send_pair(64'h1, 64'h2);
        write_set_size(7'd63);
        send_pair('1, 64'h7FFF_FFFF_FFFF_FFFF);
        send_pair(64'h8000_0000_0000_0000, '0);
        write_set_size(7'd65);
        send_pair(64'h8000_0000_0000_0000, '1);
        write_set_size(7'd127);
        send_pair('1, 64'h8000_0000_0000_0000);
        send_pair(64'h8000_0000_0000_0001, 64'h8000_0000_0000_0001);
    endtask

    // The output is held off while pairs keep arriving, so the pipeline fills and stalls its input.
    task automatic test_backpressure();
        write_set_size(7'd64);
        tx_gaps = 1'b0;
        rx_stalls = 1'b0;
        hold_req = 1'b1;
        random_pairs(30);
    endtask

    task automatic test_random_pairs();
        logic [CNT_W-1:0] sizes[10];
        sizes = '{7'd64, 7'd1, 7'd0, 7'd127, 7'd2, 7'd63, 7'd65, 7'd64, 7'd64, 7'd64};
        sizes[7] = CNT_W'($urandom_range(3, 62));
        sizes[8] = CNT_W'($urandom_range(0, 127));
        for (int i = 0; i < 10; i++)
        begin
            write_set_size(sizes[i]);
            tx_gaps = (i % 4 == 0) || (i % 4 == 2);
            rx_stalls = (i % 4 == 0) || (i % 4 == 3);
            random_pairs(PHASE_ITEMS);
        end
    endtask

    initial
    begin
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_reset_size();
        test_size_extremes();
        test_backpressure();
        test_random_pairs();
        drain();
        $display("Sent %0d set pairs and compared %0d results over %0d set size writes.",
                 pairs_sent, results_seen, sizes_used);
        $display("Covered zero, one, full and saturated sizes, a long output stall and random gaps.");
        if (errors == 0 && pending_cmp.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
